/* rtl/reconfig_slot_scheduler_defines.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef RECONFIG_SLOT_SCHEDULER_DEFINES_SVH
`define RECONFIG_SLOT_SCHEDULER_DEFINES_SVH

// Implication that must hold at every clock edge outside reset.
`define RSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define RSS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/rss_pkg.sv */
`timescale 1ns / 1ps
package rss_pkg;

  // Commands.
  localparam logic [2:0] CMD_REQUEST = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_CLOSE   = 3'd2;
  localparam logic [2:0] CMD_SCHED   = 3'd3;
  localparam logic [2:0] CMD_STATUS  = 3'd4;

  // Result kinds.
  localparam logic [3:0] KIND_QUEUED   = 4'd0;
  localparam logic [3:0] KIND_BAD_ACC  = 4'd1;
  localparam logic [3:0] KIND_BUSY     = 4'd2;
  localparam logic [3:0] KIND_RELEASED = 4'd3;
  localparam logic [3:0] KIND_NOT_OPER = 4'd4;
  localparam logic [3:0] KIND_CLOSED   = 4'd5;
  localparam logic [3:0] KIND_GRANTED  = 4'd6;
  localparam logic [3:0] KIND_LOAD_ERR = 4'd7;
  localparam logic [3:0] KIND_IDLE     = 4'd8;
  localparam logic [3:0] KIND_STATUS   = 4'd9;

  // Client states.
  localparam logic [1:0] ST_BLANK     = 2'd0;
  localparam logic [1:0] ST_QUEUED    = 2'd1;
  localparam logic [1:0] ST_OPERATING = 2'd2;

  localparam logic [3:0] ACC_COUNT_RESET = 4'd8;

  // One client table entry.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  wanted;
    logic [3:0]  held;
    logic [15:0] stamp;
  } entry_t;

  // One result as presented on the output channel.
  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] who;
    logic [1:0] slot_id;
    logic [2:0] acc_num;
    logic       reloaded;
    logic [1:0] client_state;
    logic       last;
  } res_t;

endpackage

/* rtl/rss_cmd_if.sv */
`timescale 1ns / 1ps
interface rss_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [3:0] client;
  logic [2:0] accel;
  logic [3:0] load_ok;
  modport source (output valid, cmd, client, accel, load_ok, input ready);
  modport sink (input valid, cmd, client, accel, load_ok, output ready);
endinterface

/* rtl/rss_res_if.sv */
`timescale 1ns / 1ps
interface rss_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [3:0] who;
  logic [1:0] slot_id;
  logic [2:0] acc_num;
  logic       reloaded;
  logic [1:0] client_state;
  logic       last;
  modport source (output valid, kind, who, slot_id, acc_num, reloaded, client_state, last,
                  input ready);
  modport sink (input valid, kind, who, slot_id, acc_num, reloaded, client_state, last,
                output ready);
endinterface

/* rtl/rss_cfg_if.sv */
`timescale 1ns / 1ps
interface rss_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] accel_count;
  modport source (output valid, accel_count, input ready);
  modport sink (input valid, accel_count, output ready);
endinterface

/* rtl/rss_client_mem.sv */
`timescale 1ns / 1ps
module rss_client_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output rss_pkg::entry_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  rss_pkg::entry_t wr_data_i
);

  rss_pkg::entry_t mem [DEPTH];
  rss_pkg::entry_t rd_q;
  logic [DEPTH-1:0] vld_q;
  logic rd_vld_q;

  // Storage array with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Per-entry valid bits; an entry never written reads as a blank client.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_comb begin
    rd_data_o = rd_q;
    if (!rd_vld_q) begin
      rd_data_o.status = rss_pkg::ST_BLANK;
      rd_data_o.wanted = '0;
      rd_data_o.held   = '0;
    end
  end

endmodule

/* rtl/reconfig_slot_scheduler.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Carries
// in_i     in   valid/ready    cmd, client, accel, load_ok
// res_o    out  valid/ready    kind, who, slot_id, acc_num, reloaded, client_state, last
// cfg_i    in   valid/ready    accel_count
// Request, release, close and status make one client table read and then one update.
// A schedule pass visits each slot in turn: a busy slot is skipped, and a free slot gets
// a client table scan, one entry per cycle, followed by a decision.
// Reset clears all client and slot state at once; no clearing pass is needed.
// A full output register stalls any step that must push a result until the pending result is taken.
`include "reconfig_slot_scheduler_defines.svh"
module reconfig_slot_scheduler #(
  parameter int SLOTS   = 4,
  parameter int CLIENTS = 16,
  parameter int ACCELS  = 8
) (
  input logic     clk_i,
  input logic     rst_ni,
  rss_cmd_if.sink   in_i,
  rss_res_if.source res_o,
  rss_cfg_if.sink   cfg_i
);

  localparam int CW = $clog2(CLIENTS);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CEXE = 3'd1;
  localparam logic [2:0] S_SLOT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [3:0] acc_cnt_q;
  logic [15:0] arr_q, arr_d;

  // Captured request.
  logic [2:0] cmd_q;
  logic [3:0] who_q;
  logic [CW-1:0] cli_q;
  logic [2:0] acc_q;
  logic [3:0] lok_q;

  // Slot state in flops.
  logic [SLOTS-1:0] busy_q, busy_d, hcfg_q, hcfg_d;
  logic [CW-1:0] owner_q [SLOTS];
  logic [CW-1:0] owner_d [SLOTS];
  logic [2:0] ldacc_q [SLOTS];
  logic [2:0] ldacc_d [SLOTS];

  // Scan bookkeeping.
  logic [SW:0] slot_q, slot_d;
  logic [CW-1:0] scan_q, scan_d;
  logic lv_q, lv_d, bv_q, bv_d;
  logic [CW-1:0] lc_q, lc_d, bc_q, bc_d;
  logic [15:0] lage_q, lage_d, bage_q, bage_d;
  logic [2:0] bacc_q, bacc_d;

  // Pending schedule result and output register.
  logic pend_v_q, pend_v_d;
  rss_pkg::res_t pend_q, pend_d;
  logic out_v_q, out_v_d;
  rss_pkg::res_t out_q, out_d;

  // Client table port signals.
  logic rd_en, wr_en;
  logic [CW-1:0] rd_addr, wr_addr;
  rss_pkg::entry_t rd_data, wr_data;

  logic out_free, push, accept, take;
  rss_pkg::res_t push_res, new_res;
  logic [SW-1:0] s_idx, s_rel;
  logic [15:0] age;

  rss_client_mem #(.DEPTH(CLIENTS), .AW(CW)) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_v_q || res_o.ready;
  assign s_idx       = slot_q[SW-1:0];
  assign s_rel       = rd_data.held[SW-1:0];
  assign age         = arr_q - rd_data.stamp;
  assign take        = lv_q || bv_q;

  assign res_o.valid        = out_v_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.who          = out_q.who;
  assign res_o.slot_id      = out_q.slot_id;
  assign res_o.acc_num      = out_q.acc_num;
  assign res_o.reloaded     = out_q.reloaded;
  assign res_o.client_state = out_q.client_state;
  assign res_o.last         = out_q.last;

  // Main sequencer: command decode, table update and the per-slot scan.
  always_comb begin
    state_d  = state_q;
    arr_d    = arr_q;
    busy_d   = busy_q;
    hcfg_d   = hcfg_q;
    owner_d  = owner_q;
    ldacc_d  = ldacc_q;
    slot_d   = slot_q;
    scan_d   = scan_q;
    lv_d     = lv_q;
    bv_d     = bv_q;
    lc_d     = lc_q;
    bc_d     = bc_q;
    lage_d   = lage_q;
    bage_d   = bage_q;
    bacc_d   = bacc_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = cli_q;
    wr_data  = rd_data;
    push     = 1'b0;
    push_res = '0;
    new_res  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.cmd == rss_pkg::CMD_SCHED) begin
            slot_d   = '0;
            pend_v_d = 1'b0;
            state_d  = S_SLOT;
          end else if (in_i.cmd <= rss_pkg::CMD_STATUS && 32'(in_i.client) < CLIENTS) begin
            rd_en   = 1'b1;
            rd_addr = CW'(in_i.client);
            state_d = S_CEXE;
          end
        end
      end

      S_CEXE: begin
        new_res.who  = who_q;
        new_res.last = 1'b1;
        unique case (cmd_q)
          rss_pkg::CMD_REQUEST: begin
            if ({1'b0, acc_q} >= acc_cnt_q || 32'(acc_q) >= ACCELS) begin
              new_res.kind = rss_pkg::KIND_BAD_ACC;
            end else if (rd_data.status != rss_pkg::ST_BLANK) begin
              new_res.kind = rss_pkg::KIND_BUSY;
            end else begin
              new_res.kind   = rss_pkg::KIND_QUEUED;
              wr_data.status = rss_pkg::ST_QUEUED;
              wr_data.wanted = acc_q;
              wr_data.stamp  = arr_q;
              wr_en          = out_free;
              if (out_free) begin
                arr_d = arr_q + 16'd1;
              end
            end
          end
          rss_pkg::CMD_RELEASE: begin
            if (rd_data.status != rss_pkg::ST_OPERATING) begin
              new_res.kind = rss_pkg::KIND_NOT_OPER;
            end else begin
              new_res.kind     = rss_pkg::KIND_RELEASED;
              new_res.slot_id  = 2'(s_rel);
              new_res.acc_num  = ldacc_q[s_rel];
              wr_data.status   = rss_pkg::ST_BLANK;
              wr_data.held     = '0;
              wr_en            = out_free;
              if (out_free && owner_q[s_rel] == cli_q) begin
                busy_d[s_rel]  = 1'b0;
                owner_d[s_rel] = '0;
              end
            end
          end
          rss_pkg::CMD_CLOSE: begin
            new_res.kind   = rss_pkg::KIND_CLOSED;
            wr_data.status = rss_pkg::ST_BLANK;
            wr_data.held   = '0;
            wr_en          = out_free;
            if (out_free && rd_data.status == rss_pkg::ST_OPERATING
                && owner_q[s_rel] == cli_q) begin
              busy_d[s_rel]  = 1'b0;
              owner_d[s_rel] = '0;
            end
          end
          default: begin
            new_res.kind         = rss_pkg::KIND_STATUS;
            new_res.client_state = rd_data.status;
            if (rd_data.status == rss_pkg::ST_OPERATING) begin
              new_res.slot_id  = 2'(s_rel);
              new_res.acc_num  = ldacc_q[s_rel];
            end
          end
        endcase
        if (out_free) begin
          push     = 1'b1;
          push_res = new_res;
          state_d  = S_IDLE;
        end
      end

      S_SLOT: begin
        if (32'(slot_q) >= SLOTS) begin
          state_d = S_FIN;
        end else if (busy_q[s_idx]) begin
          slot_d = slot_q + (SW+1)'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          scan_d  = '0;
          lv_d    = 1'b0;
          bv_d    = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rd_data.status == rss_pkg::ST_QUEUED) begin
          if (hcfg_q[s_idx] && rd_data.wanted == ldacc_q[s_idx]
              && (!lv_q || age > lage_q)) begin
            lv_d   = 1'b1;
            lc_d   = scan_q;
            lage_d = age;
          end
          if ({1'b0, rd_data.wanted} < acc_cnt_q && 32'(rd_data.wanted) < ACCELS
              && (!bv_q || rd_data.wanted < bacc_q
                  || (rd_data.wanted == bacc_q && age > bage_q))) begin
            bv_d   = 1'b1;
            bc_d   = scan_q;
            bage_d = age;
            bacc_d = rd_data.wanted;
          end
        end
        if (scan_q == CW'(CLIENTS - 1)) begin
          state_d = S_DEC;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q + CW'(1);
          scan_d  = scan_q + CW'(1);
        end
      end

      S_DEC: begin
        if (!take) begin
          slot_d  = slot_q + (SW+1)'(1);
          state_d = S_SLOT;
        end else if (!pend_v_q || out_free) begin
          new_res.who      = lv_q ? 4'(lc_q) : 4'(bc_q);
          new_res.slot_id  = 2'(s_idx);
          new_res.acc_num  = lv_q ? ldacc_q[s_idx] : bacc_q;
          wr_en            = 1'b1;
          wr_addr          = lv_q ? lc_q : bc_q;
          wr_data.wanted   = new_res.acc_num;
          wr_data.stamp    = arr_q;
          if (!lv_q && !lok_q[s_idx[1:0]]) begin
            new_res.kind   = rss_pkg::KIND_LOAD_ERR;
            wr_data.status = rss_pkg::ST_BLANK;
            wr_data.held   = '0;
          end else begin
            new_res.kind     = rss_pkg::KIND_GRANTED;
            new_res.reloaded = !lv_q;
            wr_data.status   = rss_pkg::ST_OPERATING;
            wr_data.held     = 4'(s_idx);
            busy_d[s_idx]    = 1'b1;
            hcfg_d[s_idx]    = 1'b1;
            owner_d[s_idx]   = wr_addr;
            ldacc_d[s_idx]   = new_res.acc_num;
          end
          push     = pend_v_q;
          push_res = pend_q;
          pend_v_d = 1'b1;
          pend_d   = new_res;
          slot_d   = slot_q + (SW+1)'(1);
          state_d  = S_SLOT;
        end
      end

      S_FIN: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_v_q) begin
            push_res = pend_q;
          end else begin
            push_res.kind = rss_pkg::KIND_IDLE;
          end
          push_res.last = 1'b1;
          pend_v_d      = 1'b0;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (push) begin
      out_v_d = 1'b1;
      out_d   = push_res;
    end else if (res_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  // Control and slot registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      acc_cnt_q <= rss_pkg::ACC_COUNT_RESET;
      arr_q     <= '0;
      busy_q    <= '0;
      hcfg_q    <= '0;
      owner_q   <= '{default: '0};
      ldacc_q   <= '{default: '0};
      slot_q    <= '0;
      scan_q    <= '0;
      lv_q      <= 1'b0;
      bv_q      <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      arr_q    <= arr_d;
      busy_q   <= busy_d;
      hcfg_q   <= hcfg_d;
      owner_q  <= owner_d;
      ldacc_q  <= ldacc_d;
      slot_q   <= slot_d;
      scan_q   <= scan_d;
      lv_q     <= lv_d;
      bv_q     <= bv_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_i.valid && cfg_i.ready) begin
        acc_cnt_q <= cfg_i.accel_count;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lc_q   <= lc_d;
    bc_q   <= bc_d;
    lage_q <= lage_d;
    bage_q <= bage_d;
    bacc_q <= bacc_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    if (accept) begin
      cmd_q <= in_i.cmd;
      who_q <= in_i.client;
      cli_q <= CW'(in_i.client);
      acc_q <= in_i.accel;
      lok_q <= in_i.load_ok;
    end
  end

  `RSS_NEVER(a_rd_wr_overlap, rd_en && wr_en, "client table read and write in one cycle")
  `RSS_ASSERT(a_grant_free_slot, (state_q == S_DEC && take && (!pend_v_q || out_free)) |-> !busy_q[s_idx], "grant to a busy slot")
  `RSS_NEVER(a_push_overrun, push && out_v_q && !res_o.ready, "result overwrote a waiting result")
  `RSS_ASSERT(a_scan_done, (state_q == S_DEC) |-> $past(state_q == S_SCAN || state_q == S_DEC), "decision without a completed scan")

endmodule

/* tb/sv/reconfig_slot_scheduler_test.sv */
`timescale 1ns / 1ps
module reconfig_slot_scheduler_test;

  localparam int NUM_SLOTS   = 4;
  localparam int NUM_CLIENTS = 16;
  localparam int NUM_ACCELS  = 8;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 300000;

  // Mirror of the scheduler tables that predicts every result.
  class slot_scoreboard;
    logic [1:0]  status [NUM_CLIENTS];
    logic [2:0]  wanted [NUM_CLIENTS];
    logic [1:0]  held [NUM_CLIENTS];
    logic [15:0] stamp [NUM_CLIENTS];
    logic [15:0] arrivals;
    logic        busy [NUM_SLOTS];
    logic [3:0]  owner [NUM_SLOTS];
    logic [2:0]  loaded [NUM_SLOTS];
    logic        has_cfg [NUM_SLOTS];
    logic [3:0]  accel_count;
    rss_pkg::res_t expected [$];
    int          errors;

    function new();
      for (int c = 0; c < NUM_CLIENTS; c++) begin
        status[c] = rss_pkg::ST_BLANK;
        wanted[c] = '0;
        held[c] = '0;
        stamp[c] = '0;
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
        busy[s] = 1'b0;
        owner[s] = '0;
        loaded[s] = '0;
        has_cfg[s] = 1'b0;
      end
      arrivals = '0;
      accel_count = rss_pkg::ACC_COUNT_RESET;
      errors = 0;
    endfunction

    function void push(logic [3:0] kind, logic [3:0] who, logic [1:0] slot,
                       logic [2:0] acc, logic rel, logic [1:0] cst);
      rss_pkg::res_t r;
      r.kind = kind;
      r.who = who;
      r.slot_id = slot;
      r.acc_num = acc;
      r.reloaded = rel;
      r.client_state = cst;
      r.last = 1'b0;
      expected.push_back(r);
    endfunction

    // Oldest queued client for an accelerator; ties go to the lowest index.
    function int oldest_waiter(logic [2:0] acc);
      int best;
      logic [15:0] best_age;
      logic [15:0] age;
      best = -1;
      best_age = '0;
      for (int c = 0; c < NUM_CLIENTS; c++) begin
        if (status[c] == rss_pkg::ST_QUEUED && wanted[c] == acc) begin
          age = arrivals - stamp[c];
          if (best < 0 || age > best_age) begin
            best = c;
            best_age = age;
          end
        end
      end
      return best;
    endfunction

    function void free_slot(int c);
      int s;
      s = held[c];
      if (owner[s] == c) begin
        busy[s] = 1'b0;
        owner[s] = '0;
      end
      held[c] = '0;
    endfunction

    // Predict the results of one accepted request.
    function void note_request(logic [2:0] cmd, logic [3:0] client, logic [2:0] acc,
                               logic [3:0] load_ok);
      int n0;
      int c;
      int lim;
      int s;
      logic [2:0] a;
      logic reload;
      n0 = expected.size();
      if (cmd > rss_pkg::CMD_STATUS) return;
      case (cmd)
        rss_pkg::CMD_SCHED: begin
          lim = (accel_count < NUM_ACCELS) ? accel_count : NUM_ACCELS;
          for (int sl = 0; sl < NUM_SLOTS; sl++) begin
            if (busy[sl]) continue;
            c = -1;
            a = '0;
            reload = 1'b0;
            if (has_cfg[sl]) begin
              a = loaded[sl];
              c = oldest_waiter(a);
            end
            if (c < 0) begin
              for (int j = 0; j < lim; j++) begin
                c = oldest_waiter(j[2:0]);
                if (c >= 0) begin
                  a = j[2:0];
                  reload = 1'b1;
                  break;
                end
              end
            end
            if (c < 0) continue;
            if (reload && !load_ok[sl]) begin
              status[c] = rss_pkg::ST_BLANK;
              held[c] = '0;
              push(rss_pkg::KIND_LOAD_ERR, c[3:0], sl[1:0], a, 1'b0, rss_pkg::ST_BLANK);
              continue;
            end
            busy[sl] = 1'b1;
            owner[sl] = c[3:0];
            loaded[sl] = a;
            has_cfg[sl] = 1'b1;
            status[c] = rss_pkg::ST_OPERATING;
            held[c] = sl[1:0];
            push(rss_pkg::KIND_GRANTED, c[3:0], sl[1:0], a, reload, rss_pkg::ST_BLANK);
          end
          if (expected.size() == n0) begin
            push(rss_pkg::KIND_IDLE, '0, '0, '0, 1'b0, rss_pkg::ST_BLANK);
          end
        end
        rss_pkg::CMD_REQUEST: begin
          if (acc >= accel_count) begin
            push(rss_pkg::KIND_BAD_ACC, client, '0, '0, 1'b0, rss_pkg::ST_BLANK);
          end else if (status[client] != rss_pkg::ST_BLANK) begin
            push(rss_pkg::KIND_BUSY, client, '0, '0, 1'b0, rss_pkg::ST_BLANK);
          end else begin
            status[client] = rss_pkg::ST_QUEUED;
            wanted[client] = acc;
            stamp[client] = arrivals;
            arrivals = arrivals + 16'd1;
            push(rss_pkg::KIND_QUEUED, client, '0, '0, 1'b0, rss_pkg::ST_BLANK);
          end
        end
        rss_pkg::CMD_RELEASE: begin
          if (status[client] != rss_pkg::ST_OPERATING) begin
            push(rss_pkg::KIND_NOT_OPER, client, '0, '0, 1'b0, rss_pkg::ST_BLANK);
          end else begin
            s = held[client];
            a = loaded[s];
            free_slot(client);
            status[client] = rss_pkg::ST_BLANK;
            push(rss_pkg::KIND_RELEASED, client, s[1:0], a, 1'b0, rss_pkg::ST_BLANK);
          end
        end
        rss_pkg::CMD_CLOSE: begin
          if (status[client] == rss_pkg::ST_OPERATING) free_slot(client);
          status[client] = rss_pkg::ST_BLANK;
          held[client] = '0;
          push(rss_pkg::KIND_CLOSED, client, '0, '0, 1'b0, rss_pkg::ST_BLANK);
        end
        default: begin
          if (status[client] == rss_pkg::ST_OPERATING) begin
            s = held[client];
            push(rss_pkg::KIND_STATUS, client, s[1:0], loaded[s], 1'b0, status[client]);
          end else begin
            push(rss_pkg::KIND_STATUS, client, '0, '0, 1'b0, status[client]);
          end
        end
      endcase
      expected[expected.size() - 1].last = 1'b1;
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(rss_pkg::res_t got);
      rss_pkg::res_t exp_r;
      if (expected.size() == 0) begin
        $error("unexpected result kind %0d who %0d", got.kind, got.who);
        errors++;
        return;
      end
      exp_r = expected.pop_front();
      if (got.kind != exp_r.kind) begin
        $error("kind expected %0d actual %0d", exp_r.kind, got.kind);
        errors++;
      end
      if (got.who != exp_r.who) begin
        $error("who expected %0d actual %0d", exp_r.who, got.who);
        errors++;
      end
      if (got.slot_id != exp_r.slot_id) begin
        $error("slot_id expected %0d actual %0d", exp_r.slot_id, got.slot_id);
        errors++;
      end
      if (got.acc_num != exp_r.acc_num) begin
        $error("acc_num expected %0d actual %0d", exp_r.acc_num, got.acc_num);
        errors++;
      end
      if (got.reloaded != exp_r.reloaded) begin
        $error("reloaded expected %0d actual %0d", exp_r.reloaded, got.reloaded);
        errors++;
      end
      if (got.client_state != exp_r.client_state) begin
        $error("client_state expected %0d actual %0d", exp_r.client_state,
               got.client_state);
        errors++;
      end
      if (got.last != exp_r.last) begin
        $error("last expected %0d actual %0d", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  slot_scoreboard sb = new();

  rss_cmd_if cmd_ch ();
  rss_res_if res_ch ();
  rss_cfg_if cfg_ch ();

  reconfig_slot_scheduler uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .res_o (res_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always #5 clk_i = ~clk_i;

  // Cycle limit guards against a hang.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side stalls at random.
  always @(negedge clk_i) begin
    res_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk_i) begin
    rss_pkg::res_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.kind = res_ch.kind;
      got.who = res_ch.who;
      got.slot_id = res_ch.slot_id;
      got.acc_num = res_ch.acc_num;
      got.reloaded = res_ch.reloaded;
      got.client_state = res_ch.client_state;
      got.last = res_ch.last;
      sb.check_result(got);
    end
  end

  // Drive one request; called and returning at a falling edge.
  task automatic send_request(logic [2:0] cmd, logic [3:0] client, logic [2:0] acc,
                              logic [3:0] load_ok);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= cmd;
    cmd_ch.client <= client;
    cmd_ch.accel <= acc;
    cmd_ch.load_ok <= load_ok;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_request(cmd, client, acc, load_ok);
    @(negedge clk_i);
  endtask

  // Let all predicted results drain, then give the block time to settle.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_accel_count(logic [3:0] count);
    cfg_ch.valid <= 1'b1;
    cfg_ch.accel_count <= count;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.accel_count = count;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed traffic with a share of noise and refused requests.
  task automatic random_traffic(int count);
    int done;
    int pick;
    logic [2:0] acc;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 9) < 8 && sb.accel_count > 0)
          acc = 3'($urandom_range(0, sb.accel_count - 1));
        else
          acc = 3'($urandom_range(0, 7));
        send_request(rss_pkg::CMD_REQUEST, 4'($urandom_range(0, 15)), acc,
                     4'($urandom_range(0, 15)));
      end else if (pick < 55) begin
        send_request(rss_pkg::CMD_SCHED, 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      end else if (pick < 67) begin
        send_request(rss_pkg::CMD_RELEASE, 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      end else if (pick < 75) begin
        send_request(rss_pkg::CMD_CLOSE, 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      end else if (pick < 92) begin
        send_request(rss_pkg::CMD_STATUS, 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      end else begin
        // Unknown commands are ignored and do not count.
        send_request(3'($urandom_range(rss_pkg::CMD_STATUS + 1, 7)),
                     4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)));
        done--;
      end
      done++;
    end
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = '0;
    cmd_ch.client = '0;
    cmd_ch.accel = '0;
    cmd_ch.load_ok = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.accel_count = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part with every accelerator present.
    send_idle_pct = 33;
    recv_idle_pct = 54;
    write_accel_count(4'd8);
    send_request(rss_pkg::CMD_REQUEST, 4'd0, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd15, 3'd7, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd0, 3'd3, 4'd0);
    send_request(rss_pkg::CMD_STATUS, 4'd0, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_RELEASE, 4'd0, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_SCHED, 4'd0, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd1, 3'd2, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd2, 3'd2, 4'd0);
    send_request(rss_pkg::CMD_SCHED, 4'd0, 3'd0, 4'hF);
    send_request(rss_pkg::CMD_STATUS, 4'd1, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_RELEASE, 4'd1, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd3, 3'd2, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd4, 3'd5, 4'd0);
    send_request(rss_pkg::CMD_SCHED, 4'd0, 3'd0, 4'hF);
    send_request(rss_pkg::CMD_CLOSE, 4'd2, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_STATUS, 4'd3, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_SCHED, 4'd15, 3'd7, 4'd0);
    send_request(3'd7, 4'd9, 3'd1, 4'd5);
    send_request(rss_pkg::CMD_CLOSE, 4'd9, 3'd0, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd5, 3'd1, 4'd0);
    send_request(rss_pkg::CMD_CLOSE, 4'd5, 3'd0, 4'd0);
    drain();

    // Refused ids, checked ahead of the busy case; slot 2 keeps accelerator 5.
    write_accel_count(4'd3);
    send_request(rss_pkg::CMD_REQUEST, 4'd6, 3'd7, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd4, 3'd6, 4'd0);
    send_request(rss_pkg::CMD_REQUEST, 4'd7, 3'd2, 4'd0);
    send_request(rss_pkg::CMD_SCHED, 4'd0, 3'd0, 4'hA);
    drain();

    // Random phases across register settings and idling patterns.
    write_accel_count(4'd1);
    random_traffic(25);
    drain();

    send_idle_pct = 54;
    recv_idle_pct = 33;
    write_accel_count(4'd5);
    random_traffic(35);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_accel_count(4'd8);
    random_traffic(35);
    drain();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
